FILE: hw/rtl/ipid_pkg.sv
// Shared types, widths and register codes for the incremental PID current loop.
// Depends on nothing; every module of the block imports it.
package ipid_pkg;

   // Channel and field widths
   localparam int NUM_CHANNELS   = 3;
   localparam int CH_W           = 2;
   localparam int NUM_OFFSETS    = 3;
   localparam int GAIN_FRAC_BITS = 12;
   localparam int GAIN_W         = 16;
   localparam int LIMIT_W        = 15;
   localparam int OFFSET_W       = 12;
   localparam int SP_W           = 13;
   localparam int MEAS_W         = 12;
   localparam int DUTY_W         = 15;

   // Internal arithmetic widths
   localparam int ERR_W  = 14;   // setpoint - measured + offset
   localparam int DP_W   = 15;   // e - e1
   localparam int DD_W   = 17;   // e - 2*e1 + e2
   localparam int ACC_W  = 16;   // stored drive accumulator

   // Decoupling queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PROP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_INTEG  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_DERIV  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_CH0  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_CH1  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_CH2  = 3'd6;

   // Configuration as seen by the front and back parts
   typedef struct packed {
      logic [GAIN_W-1:0]                     gain_prop;
      logic [GAIN_W-1:0]                     gain_integ;
      logic [GAIN_W-1:0]                     gain_deriv;
      logic [LIMIT_W-1:0]                    drive_limit;
      logic [NUM_OFFSETS-1:0][OFFSET_W-1:0]  offset;
   } cfg_type;

   // One classified item travelling from front to back
   typedef struct packed {
      logic [CH_W-1:0]         ch;
      logic                    ch_ok;
      logic                    sp_neg;
      logic                    sp_pos;
      logic signed [ERR_W-1:0] err;
      logic signed [DP_W-1:0]  err_diff;
      logic signed [DD_W-1:0]  err_curv;
   } work_type;

endpackage

FILE: hw/rtl/ipid_front.sv
// Front part: accepts items, forms the error and its differences, keeps the
// per-channel error history. Depends on ipid_pkg.
module ipid_front
   import ipid_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CH_W-1:0]   req_channel,
   input  logic [SP_W-1:0]   req_setpoint,
   input  logic [MEAS_W-1:0] req_measured,
   input  logic              q_full,
   output logic              push,
   output work_type          push_item
);

   logic signed [ERR_W-1:0] err_now_ff  [NUM_CHANNELS];
   logic signed [ERR_W-1:0] err_now_in  [NUM_CHANNELS];
   logic signed [ERR_W-1:0] err_last_ff [NUM_CHANNELS];
   logic signed [ERR_W-1:0] err_last_in [NUM_CHANNELS];

   logic [OFFSET_W-1:0]     off_sel;
   logic signed [ERR_W-1:0] e1;
   logic signed [ERR_W-1:0] e2;
   logic signed [ERR_W-1:0] err;
   logic                    ch_ok;

   // Stall only while the queue has no room
   assign req_stall = q_full;
   assign push      = req_valid && !q_full;
   assign ch_ok     = 32'(req_channel) < NUM_CHANNELS;

   // Select the channel's offset and earlier errors
   always_comb begin
      off_sel = '0;
      e1      = '0;
      e2      = '0;
      for (int k = 0; k < NUM_OFFSETS; k++) begin
         if (32'(req_channel) == k) begin
            off_sel = cfg.offset[k];
         end
      end
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         if (32'(req_channel) == k) begin
            e1 = err_now_ff[k];
            e2 = err_last_ff[k];
         end
      end
   end

   // Form the error and its first and second differences
   always_comb begin
      err = {{(ERR_W-SP_W){req_setpoint[SP_W-1]}}, req_setpoint}
          - {{(ERR_W-MEAS_W){1'b0}}, req_measured}
          + {{(ERR_W-OFFSET_W){1'b0}}, off_sel};
      push_item.ch       = req_channel;
      push_item.ch_ok    = ch_ok;
      push_item.sp_neg   = req_setpoint[SP_W-1];
      push_item.sp_pos   = !req_setpoint[SP_W-1] && (req_setpoint != '0);
      push_item.err      = err;
      push_item.err_diff = {err[ERR_W-1], err} - {e1[ERR_W-1], e1};
      push_item.err_curv = {{(DD_W-ERR_W){err[ERR_W-1]}}, err}
                         - {{(DD_W-ERR_W-1){e1[ERR_W-1]}}, e1, 1'b0}
                         + {{(DD_W-ERR_W){e2[ERR_W-1]}}, e2};
   end

   // Shift the history of the addressed channel; drop unknown channels
   always_comb begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         err_now_in[k]  = err_now_ff[k];
         err_last_in[k] = err_last_ff[k];
         if (push && ch_ok && (32'(req_channel) == k)) begin
            err_now_in[k]  = err;
            err_last_in[k] = err_now_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            err_now_ff[k]  <= '0;
            err_last_ff[k] <= '0;
         end
      end else begin
         err_now_ff  <= err_now_in;
         err_last_ff <= err_last_in;
      end
   end

endmodule

FILE: hw/rtl/ipid_queue.sv
// Short queue between the front and back parts of the PID current loop.
// Depends on ipid_pkg for the item type and depth.
module ipid_queue
   import ipid_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_item,
   input  logic     pop,
   output work_type pop_item,
   output logic     full,
   output logic     empty
);

   work_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;

   assign full     = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_item = entry_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("item pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("item popped from empty queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff) + QCNT_W'($past(push))
                - QCNT_W'($past(pop))))
      else $error("queue fill count out of step");

endmodule

FILE: hw/rtl/ipid_back.sv
// Back part: gain multiplies, truncating scale, accumulator update with sign
// rule and clamp, and the output register. Depends on ipid_pkg.
module ipid_back
   import ipid_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              q_empty,
   input  work_type          q_item,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CH_W-1:0]   rsp_out_channel,
   output logic [DUTY_W-1:0] rsp_duty_reverse,
   output logic [DUTY_W-1:0] rsp_duty_forward
);

   localparam int PP_W  = GAIN_W + 1 + DP_W;
   localparam int PI_W  = GAIN_W + 1 + ERR_W;
   localparam int PD_W  = GAIN_W + 1 + DD_W;
   localparam int SUM_W = 24;

   // Divide by 2^GAIN_FRAC_BITS, truncating toward zero
   function automatic logic signed [SUM_W-1:0] scale_down(input logic signed [PD_W-1:0] p);
      logic signed [PD_W-1:0] biased;
      biased = p + (p[PD_W-1] ? PD_W'((1 << GAIN_FRAC_BITS) - 1) : PD_W'(0));
      return SUM_W'(biased >>> GAIN_FRAC_BITS);
   endfunction

   // Stage flow control
   logic adv1;
   logic adv2;
   logic adv3;

   logic v1_ff;
   logic v1_in;
   logic v2_ff;
   logic v2_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;

   // Stage one: raw products
   logic [CH_W-1:0]        s1_ch_ff;
   logic                   s1_ch_ok_ff;
   logic                   s1_sp_neg_ff;
   logic                   s1_sp_pos_ff;
   logic signed [PP_W-1:0] s1_prod_p_ff;
   logic signed [PI_W-1:0] s1_prod_i_ff;
   logic signed [PD_W-1:0] s1_prod_d_ff;

   // Stage two: scaled PID increment
   logic [CH_W-1:0]         s2_ch_ff;
   logic                    s2_ch_ok_ff;
   logic                    s2_sp_neg_ff;
   logic                    s2_sp_pos_ff;
   logic signed [SUM_W-1:0] s2_pid_sum_ff;
   logic signed [SUM_W-1:0] pid_sum_in;

   // Stage three: accumulator and duties
   logic signed [ACC_W-1:0] accum_ff [NUM_CHANNELS];
   logic signed [ACC_W-1:0] accum_in [NUM_CHANNELS];
   logic signed [ACC_W-1:0] acc_sel;
   logic signed [SUM_W-1:0] acc_sum;
   logic signed [SUM_W-1:0] acc_signed;
   logic signed [SUM_W-1:0] acc_clamped;
   logic signed [SUM_W-1:0] lim_pos;
   logic signed [SUM_W-1:0] lim_neg;
   logic [CH_W-1:0]         rsp_channel_ff;
   logic [DUTY_W-1:0]       duty_rev_ff;
   logic [DUTY_W-1:0]       duty_rev_in;
   logic [DUTY_W-1:0]       duty_fwd_ff;
   logic [DUTY_W-1:0]       duty_fwd_in;

   assign adv3 = !rsp_valid_ff || !rsp_stall;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign pop  = adv1 && !q_empty;

   assign v1_in        = adv1 ? !q_empty : v1_ff;
   assign v2_in        = adv2 ? v1_ff : v2_ff;
   assign rsp_valid_in = adv3 ? v2_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Multiply the error terms by their gains
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ch_ff     <= q_item.ch;
         s1_ch_ok_ff  <= q_item.ch_ok;
         s1_sp_neg_ff <= q_item.sp_neg;
         s1_sp_pos_ff <= q_item.sp_pos;
         s1_prod_p_ff <= $signed({1'b0, cfg.gain_prop}) * q_item.err_diff;
         s1_prod_i_ff <= $signed({1'b0, cfg.gain_integ}) * q_item.err;
         s1_prod_d_ff <= $signed({1'b0, cfg.gain_deriv}) * q_item.err_curv;
      end
   end

   // Scale each product and sum the three terms
   assign pid_sum_in = scale_down(PD_W'(s1_prod_p_ff))
                     + scale_down(PD_W'(s1_prod_i_ff))
                     + scale_down(s1_prod_d_ff);

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_ch_ff      <= s1_ch_ff;
         s2_ch_ok_ff   <= s1_ch_ok_ff;
         s2_sp_neg_ff  <= s1_sp_neg_ff;
         s2_sp_pos_ff  <= s1_sp_pos_ff;
         s2_pid_sum_ff <= pid_sum_in;
      end
   end

   // Add to the accumulator, apply the sign rule and the clamp
   always_comb begin
      acc_sel = '0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         if (32'(s2_ch_ff) == k) begin
            acc_sel = accum_ff[k];
         end
      end
      acc_sum = SUM_W'(acc_sel) + s2_pid_sum_ff;
      lim_pos = {{(SUM_W-LIMIT_W){1'b0}}, cfg.drive_limit};
      lim_neg = -lim_pos;
      acc_signed = acc_sum;
      if (acc_sum < 0 && !s2_sp_neg_ff) begin
         acc_signed = '0;
      end
      if (acc_sum > 0 && s2_sp_neg_ff) begin
         acc_signed = '0;
      end
      if (acc_signed > lim_pos) begin
         acc_clamped = lim_pos;
      end else if (acc_signed < lim_neg) begin
         acc_clamped = lim_neg;
      end else begin
         acc_clamped = acc_signed;
      end
   end

   // Steer the clamped value onto one half of the bridge
   always_comb begin
      duty_fwd_in = '0;
      duty_rev_in = '0;
      if (s2_ch_ok_ff) begin
         if (acc_clamped > 0 && s2_sp_pos_ff) begin
            duty_fwd_in = DUTY_W'(acc_clamped);
         end else if (acc_clamped < 0 && s2_sp_neg_ff) begin
            duty_rev_in = DUTY_W'(-acc_clamped);
         end
      end
   end

   // Write back the accumulator when the item leaves stage two
   always_comb begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         accum_in[k] = accum_ff[k];
         if (adv3 && v2_ff && s2_ch_ok_ff && (32'(s2_ch_ff) == k)) begin
            accum_in[k] = ACC_W'(acc_clamped);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            accum_ff[k] <= '0;
         end
      end else begin
         accum_ff <= accum_in;
      end
   end

   // Output register; hold while stalled
   always_ff @(posedge clock) begin
      if (adv3) begin
         rsp_channel_ff <= s2_ch_ff;
         duty_rev_ff    <= duty_rev_in;
         duty_fwd_ff    <= duty_fwd_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_channel  = rsp_channel_ff;
   assign rsp_duty_reverse = duty_rev_ff;
   assign rsp_duty_forward = duty_fwd_ff;

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (duty_rev_ff == '0 || duty_fwd_ff == '0))
      else $error("both bridge halves driven");

   a_bad_channel_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (32'(rsp_channel_ff) >= NUM_CHANNELS))
      |-> (duty_rev_ff == '0 && duty_fwd_ff == '0))
      else $error("duty on unknown channel");

   a_pop_fills: assert property (@(posedge clock) disable iff (reset)
      pop |=> v1_ff) else $error("popped item lost before stage one");

endmodule

FILE: hw/rtl/incremental_pid_current_loop.sv
// Three-channel incremental PID current loop for H-bridge motors.
// Channels: req_* carries one control tick (channel, setpoint, measured);
// rsp_* returns one item per tick with the channel and the two PWM duties.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. csr_* writes the gains, drive limit and sensor offsets; write it
// only while no item is in flight.
// A result passes through the queue, the multiply stage, the scale-and-sum
// stage and the accumulator and output register. Throughput: one item per
// cycle while rsp_stall is low, set by the accumulator read-modify-write
// within the last stage.
// A four-entry queue parts the front from the back; req_stall rises only
// when that queue is full, so the input keeps flowing through short
// receiver stalls, and a stalled result holds on the output register.
// Reset restores the default gains, limit and offsets and clears the
// error history and accumulators of every channel.
// Depends on ipid_pkg, ipid_front, ipid_queue and ipid_back.
module incremental_pid_current_loop
   import ipid_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CH_W-1:0]       req_channel,
   input  logic [SP_W-1:0]       req_setpoint,
   input  logic [MEAS_W-1:0]     req_measured,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CH_W-1:0]       rsp_out_channel,
   output logic [DUTY_W-1:0]     rsp_duty_reverse,
   output logic [DUTY_W-1:0]     rsp_duty_forward
);

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   logic     push;
   work_type push_item;
   logic     pop;
   work_type pop_item;
   logic     q_full;
   logic     q_empty;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_GAIN_PROP:   cfg_in.gain_prop   = csr_data;
            CSR_GAIN_INTEG:  cfg_in.gain_integ  = csr_data;
            CSR_GAIN_DERIV:  cfg_in.gain_deriv  = csr_data;
            CSR_DRIVE_LIMIT: cfg_in.drive_limit = csr_data[LIMIT_W-1:0];
            CSR_OFFSET_CH0:  cfg_in.offset[0]   = csr_data[OFFSET_W-1:0];
            CSR_OFFSET_CH1:  cfg_in.offset[1]   = csr_data[OFFSET_W-1:0];
            CSR_OFFSET_CH2:  cfg_in.offset[2]   = csr_data[OFFSET_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_prop   <= GAIN_W'(4915);
         cfg_ff.gain_integ  <= GAIN_W'(819);
         cfg_ff.gain_deriv  <= '0;
         cfg_ff.drive_limit <= LIMIT_W'(3500);
         cfg_ff.offset      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ipid_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_channel  (req_channel),
      .req_setpoint (req_setpoint),
      .req_measured (req_measured),
      .q_full       (q_full),
      .push         (push),
      .push_item    (push_item)
   );

   ipid_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   ipid_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_empty          (q_empty),
      .q_item           (pop_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_duty_reverse (rsp_duty_reverse),
      .rsp_duty_forward (rsp_duty_forward)
   );

endmodule

FILE: tb/incremental_pid_current_loop_tb.sv
// Self-checking testbench for the incremental PID current loop: directed ticks, then
// random control sequences under several gain settings and handshake idle patterns.
// Depends on ipid_pkg and incremental_pid_current_loop.
module incremental_pid_current_loop_tb;
   import ipid_pkg::*;

   localparam int RESET_CYCLES = 10;
   localparam int LATENCY      = 3;
   localparam int QUIET_CYCLES = LATENCY + 5;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_LIMIT = 10;
   localparam int PHASE_ITEMS  = 45;
   localparam int NUM_SETTINGS = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [CH_W-1:0]   ch;
      logic [DUTY_W-1:0] rev;
      logic [DUTY_W-1:0] fwd;
   } duty_pair_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CH_W-1:0]       req_channel = '0;
   logic [SP_W-1:0]       req_setpoint = '0;
   logic [MEAS_W-1:0]     req_measured = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CH_W-1:0]       rsp_out_channel;
   logic [DUTY_W-1:0]     rsp_duty_reverse;
   logic [DUTY_W-1:0]     rsp_duty_forward;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int fail_count    = 0;
   int cycle_count   = 0;

   duty_pair_type expected_duties[$];

   // Predictor copy of the registers and the per-channel loop state
   logic [GAIN_W-1:0]   kp, ki, kd;
   logic [LIMIT_W-1:0]  limit;
   logic [OFFSET_W-1:0] offset [NUM_OFFSETS];
   int err_now_h  [NUM_CHANNELS];
   int err_last_h [NUM_CHANNELS];
   int err_prev_h [NUM_CHANNELS];
   int accum_h    [NUM_CHANNELS];
   int target_sp  [NUM_CHANNELS];

   incremental_pid_current_loop dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_channel      (req_channel),
      .req_setpoint     (req_setpoint),
      .req_measured     (req_measured),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_duty_reverse (rsp_duty_reverse),
      .rsp_duty_forward (rsp_duty_forward)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   // Q4.12 product, truncated toward zero
   function automatic longint scaled(input logic [GAIN_W-1:0] g, input longint x);
      longint gl;
      gl = longint'(g);
      return (gl * x) / (longint'(1) << GAIN_FRAC_BITS);
   endfunction

   // Advance one channel's loop state and return the duties it drives
   function automatic duty_pair_type predict_duties(input logic [CH_W-1:0] ch,
                                                    input logic [SP_W-1:0] sp_bits,
                                                    input logic [MEAS_W-1:0] meas);
      duty_pair_type d;
      int sp, m, off;
      longint e, e1, e2, acc, lim, mag;
      d.ch  = ch;
      d.rev = '0;
      d.fwd = '0;
      if (ch >= NUM_CHANNELS) return d;
      sp  = int'($signed(sp_bits));
      m   = int'(meas);
      off = (ch < NUM_OFFSETS) ? int'(offset[ch]) : 0;
      err_prev_h[ch] = err_last_h[ch];
      err_last_h[ch] = err_now_h[ch];
      err_now_h[ch]  = sp - m + off;
      e   = longint'(err_now_h[ch]);
      e1  = longint'(err_last_h[ch]);
      e2  = longint'(err_prev_h[ch]);
      acc = longint'(accum_h[ch]) + scaled(kp, e - e1) + scaled(ki, e)
            + scaled(kd, e - 2 * e1 + e2);
      // Drop drive that opposes the commanded direction, then clamp
      if (acc < 0 && sp >= 0) acc = 0;
      if (acc > 0 && sp < 0) acc = 0;
      lim = longint'(limit);
      if (acc > lim) acc = lim;
      else if (acc < -lim) acc = -lim;
      accum_h[ch] = int'(acc);
      if (acc > 0 && sp > 0) begin
         d.fwd = acc[DUTY_W-1:0];
      end else if (acc < 0 && sp < 0) begin
         mag   = -acc;
         d.rev = mag[DUTY_W-1:0];
      end
      return d;
   endfunction

   // Check each accepted result against the oldest prediction; pick the next stall
   always @(posedge clock) begin
      duty_pair_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_duties.size() == 0) begin
               note_failure($sformatf("unexpected item: ch %0d rev %0d fwd %0d",
                                      rsp_out_channel, rsp_duty_reverse, rsp_duty_forward));
            end else begin
               want = expected_duties.pop_front();
               if (rsp_out_channel !== want.ch || rsp_duty_reverse !== want.rev ||
                   rsp_duty_forward !== want.fwd)
                  note_failure($sformatf(
                     "mismatch: expected ch %0d rev %0d fwd %0d, got ch %0d rev %0d fwd %0d",
                     want.ch, want.rev, want.fwd,
                     rsp_out_channel, rsp_duty_reverse, rsp_duty_forward));
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Offer one tick, hold it until accepted, then record its prediction
   task automatic send_tick(input int ch, input int sp, input int meas);
      logic [CH_W-1:0]   c;
      logic [SP_W-1:0]   s;
      logic [MEAS_W-1:0] m;
      c = ch[CH_W-1:0];
      s = sp[SP_W-1:0];
      m = meas[MEAS_W-1:0];
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_channel  <= c;
      req_setpoint <= s;
      req_measured <= m;
      do @(posedge clock); while (req_stall);
      expected_duties.push_back(predict_duties(c, s, m));
   endtask

   // Stop sending and let every item in flight come out
   task automatic wait_for_quiet;
      req_valid <= 1'b0;
      while (expected_duties.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // One register write; the caller lowers the write enable
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      case (idx)
         CSR_GAIN_PROP:   kp = data;
         CSR_GAIN_INTEG:  ki = data;
         CSR_GAIN_DERIV:  kd = data;
         CSR_DRIVE_LIMIT: limit = data[LIMIT_W-1:0];
         CSR_OFFSET_CH0:  offset[0] = data[OFFSET_W-1:0];
         CSR_OFFSET_CH1:  offset[1] = data[OFFSET_W-1:0];
         CSR_OFFSET_CH2:  offset[2] = data[OFFSET_W-1:0];
         default: ;
      endcase
   endtask

   // Write every register, plus the unused index, which must change nothing
   task automatic load_settings(input logic [CSR_DATA_W-1:0] gp, gi, gd, lim, o0, o1, o2);
      write_reg(CSR_GAIN_PROP, gp);
      write_reg(CSR_GAIN_INTEG, gi);
      write_reg(CSR_GAIN_DERIV, gd);
      write_reg(CSR_DRIVE_LIMIT, lim);
      write_reg(CSR_OFFSET_CH0, o0);
      write_reg(CSR_OFFSET_CH1, o1);
      write_reg(CSR_OFFSET_CH2, o2);
      write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
      csr_write <= 1'b0;
   endtask

   task automatic test_reset_defaults;
      send_tick(0, 4095, 0);
      send_tick(0, 4095, 4095);
      send_tick(1, -4096, 0);
      send_tick(1, -4096, 4095);
      send_tick(2, 1, 4095);
   endtask

   // A positive accumulator survives a zero setpoint but drives nothing
   task automatic test_zero_setpoint;
      send_tick(2, 2000, 0);
      send_tick(2, 0, 0);
      send_tick(2, 0, 4095);
   endtask

   // The unused channel echoes back with zero duties and leaves state alone
   task automatic test_unused_channel;
      send_tick(3, 4095, 4095);
      send_tick(3, -4096, 0);
      send_tick(0, 100, 50);
   endtask

   task automatic test_register_extremes;
      wait_for_quiet();
      load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF);
      send_tick(0, 4095, 0);
      send_tick(0, 4095, 0);
      send_tick(0, -4096, 4095);
      send_tick(1, -4096, 4095);
      send_tick(1, -4096, 4095);
      send_tick(2, -1, 0);
      send_tick(3, 4095, 0);
      wait_for_quiet();
      load_settings('0, '0, '0, '0, '0, '0, '0);
      send_tick(0, 4095, 0);
      send_tick(1, -4096, 4095);
      send_tick(2, -4096, 0);
   endtask

   // Mostly tracking sequences: held setpoints with measured current near them
   task automatic send_random_tick;
      int r, ch, meas;
      r = $urandom_range(99);
      if (r < 4) begin
         send_tick(3, int'($urandom_range(8191)) - 4096, $urandom_range(4095));
      end else if (r < 30) begin
         send_tick($urandom_range(2), int'($urandom_range(8191)) - 4096,
                   $urandom_range(4095));
      end else begin
         ch = $urandom_range(2);
         if ($urandom_range(9) == 0) target_sp[ch] = int'($urandom_range(8191)) - 4096;
         meas = (target_sp[ch] < 0 ? -target_sp[ch] : target_sp[ch])
                + int'($urandom_range(128)) - 64;
         if (meas < 0) meas = 0;
         if (meas > 4095) meas = 4095;
         send_tick(ch, target_sp[ch], meas);
      end
   endtask

   task automatic test_random_settings;
      int s, p, k;
      for (s = 0; s < NUM_SETTINGS; s++) begin
         wait_for_quiet();
         case (s)
            0: load_settings(16'd4915, 16'd819, 16'd0, 16'd3500, 16'd0, 16'd0, 16'd0);
            1: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF);
            2: load_settings('0, '0, '0, '0, '0, '0, '0);
            default: load_settings(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                                   CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                                   CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                                   CSR_DATA_W'($urandom));
         endcase
         for (p = 0; p < 4; p++) begin
            case (p)
               0: begin send_idle_pct = 0;  stall_pct = 0;  end
               1: begin send_idle_pct = 50; stall_pct = 0;  end
               2: begin send_idle_pct = 0;  stall_pct = 50; end
               default: begin send_idle_pct = 6; stall_pct = 6; end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) send_random_tick();
         end
      end
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   initial begin
      kp    = 16'd4915;
      ki    = 16'd819;
      kd    = '0;
      limit = 15'd3500;
      for (int i = 0; i < NUM_OFFSETS; i++) offset[i] = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         err_now_h[i]  = 0;
         err_last_h[i] = 0;
         err_prev_h[i] = 0;
         accum_h[i]    = 0;
         target_sp[i]  = 0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_zero_setpoint();
      test_unused_channel();
      test_register_extremes();
      test_random_settings();

      wait_for_quiet();
      if (expected_duties.size() != 0)
         note_failure($sformatf("%0d items never came out", expected_duties.size()));
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
